### sv/iau_pkg.sv
// Shared types, constants and helpers of the interval arithmetic unit.
`default_nettype none
package iau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int FIFO_D    = 2;

  localparam logic signed [PROD_W-1:0] W_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] W_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_SUBSET = 3'd4,
    OP_EQUAL  = 3'd5,
    OP_CENTER = 3'd6,
    OP_WIDTH  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_SPAN = 2'd1,
    ST_BAD_OPND = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] a_lo;
    logic signed [DATA_W-1:0] a_hi;
    logic signed [DATA_W-1:0] b_lo;
    logic signed [DATA_W-1:0] b_hi;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_lo;
    logic signed [DATA_W-1:0] res_hi;
    logic                     flag;
    logic [1:0]               status;
  } out_item_t;

  // queued item with its classification
  typedef struct packed {
    in_item_t item;
    logic     bad;
    logic     span;
  } cls_item_t;

  typedef struct packed {
    logic      valid;
    cls_item_t ent;
  } q_head_t;

  // back end stage record for everything but the quotients
  typedef struct packed {
    logic      valid;
    logic      div_ok;
    out_item_t res;
  } mid_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } sat_t;

  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[DATA_W-1:0];
    if (v > W_MAX) begin
      r.sat = 1'b1;
      r.val = W_MAX[DATA_W-1:0];
    end else if (v < W_MIN) begin
      r.sat = 1'b1;
      r.val = W_MIN[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/iau_front.sv
// Front end: classifies incoming items and queues them for the back end.
`default_nettype none
module iau_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire iau_pkg::in_item_t  in_data,
  input  wire logic               pop,
  output iau_pkg::q_head_t        head
);

  iau_pkg::cls_item_t ent;
  iau_pkg::cls_item_t mem_r [iau_pkg::FIFO_D];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push;
  logic               b_chk;

  // B is only checked for ops that use it
  always_comb begin
    b_chk = (in_data.req_type != iau_pkg::OP_CENTER) &&
            (in_data.req_type != iau_pkg::OP_WIDTH);
    ent.item = in_data;
    ent.bad  = (in_data.a_lo > in_data.a_hi) || (b_chk && (in_data.b_lo > in_data.b_hi));
    ent.span = (in_data.b_lo == '0) || (in_data.b_hi == '0) ||
               (in_data.b_lo[iau_pkg::DATA_W-1] != in_data.b_hi[iau_pkg::DATA_W-1]);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= ent;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.ent   = mem_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("front queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> cnt_r != 2'd0)
    else $error("pop from empty front queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("front queue lost an entry");

endmodule
`default_nettype wire

### sv/iau_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
`default_nettype none
module iau_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [iau_pkg::NUM_W-1:0]   num_i,
  input  wire logic [iau_pkg::DATA_W-1:0]  den_i,
  input  wire logic                        neg_i,
  output logic [iau_pkg::NUM_W-1:0]        quo_o,
  output logic                             neg_o
);

  localparam int NW = iau_pkg::NUM_W;
  localparam int DW = iau_pkg::DATA_W;

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] den_r [NW];
  logic          neg_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [NW-1:0] nq_in;
    logic          neg_in;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign neg_in = neg_r[i-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[NW-1]};
      diff  = {1'b0, trial} - {2'b00, den_in};
      ge    = ~diff[DW+1];
    end

    // dividend bits shift out at the top, quotient bits shift in at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_r[i]  <= {nq_in[NW-2:0], ge};
        den_r[i] <= den_in;
        neg_r[i] <= neg_in;
      end
    end
  end

  assign quo_o = nq_r[NW-1];
  assign neg_o = neg_r[NW-1];

endmodule
`default_nettype wire

### sv/iau_back.sv
// Back end: multiply, divide and endpoint datapath with a two-entry output buffer.
`default_nettype none
module iau_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire iau_pkg::q_head_t   head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output iau_pkg::out_item_t      out_data
);

  localparam int NW = iau_pkg::NUM_W;
  localparam int DW = iau_pkg::DATA_W;
  localparam int PW = iau_pkg::PROD_W;
  localparam int FB = iau_pkg::FRAC_BITS;

  logic                en;
  logic [1:0]          cnt_r, cnt_nxt;
  iau_pkg::out_item_t  buf_r [2];
  logic                out_fire, push;

  // ---- stage 1: products and divider operand selection
  logic signed [DW-1:0] alo, ahi, blo, bhi;
  logic signed [DW-1:0] lo_num, lo_den, hi_num, hi_den;
  logic [NW-1:0]        lo_nmag, hi_nmag;
  logic [DW-1:0]        lo_dmag, hi_dmag;
  logic                 lo_neg, hi_neg;
  logic signed [PW-1:0] p0, p1, p2, p3;

  logic                 s1_v_r;
  iau_pkg::cls_item_t   s1_ent_r;
  logic signed [PW-1:0] prod_r [4];

  assign en  = (cnt_r != 2'd2);
  assign pop = en && head.valid;

  always_comb begin
    alo = head.ent.item.a_lo;
    ahi = head.ent.item.a_hi;
    blo = head.ent.item.b_lo;
    bhi = head.ent.item.b_hi;
    p0  = alo * blo;
    p1  = alo * bhi;
    p2  = ahi * blo;
    p3  = ahi * bhi;
    // quotient is monotone in each operand, so the extreme corners follow from signs
    if (!blo[DW-1]) begin
      lo_num = alo;
      lo_den = alo[DW-1] ? blo : bhi;
      hi_num = ahi;
      hi_den = ahi[DW-1] ? bhi : blo;
    end else begin
      lo_num = ahi;
      lo_den = ahi[DW-1] ? blo : bhi;
      hi_num = alo;
      hi_den = alo[DW-1] ? bhi : blo;
    end
    lo_nmag = NW'(iau_pkg::abs32(lo_num)) << FB;
    hi_nmag = NW'(iau_pkg::abs32(hi_num)) << FB;
    lo_dmag = iau_pkg::abs32(lo_den);
    hi_dmag = iau_pkg::abs32(hi_den);
    lo_neg  = lo_num[DW-1] ^ lo_den[DW-1];
    hi_neg  = hi_num[DW-1] ^ hi_den[DW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ent_r  <= head.ent;
      prod_r[0] <= p0;
      prod_r[1] <= p1;
      prod_r[2] <= p2;
      prod_r[3] <= p3;
    end
  end

  logic [NW-1:0] qlo, qhi;
  logic          qlo_neg, qhi_neg;

  iau_div u_div_lo (
    .clk   (clk),
    .en    (en),
    .num_i (lo_nmag),
    .den_i (lo_dmag),
    .neg_i (lo_neg),
    .quo_o (qlo),
    .neg_o (qlo_neg)
  );

  iau_div u_div_hi (
    .clk   (clk),
    .en    (en),
    .num_i (hi_nmag),
    .den_i (hi_dmag),
    .neg_i (hi_neg),
    .quo_o (qhi),
    .neg_o (qhi_neg)
  );

  // ---- stage 2: everything except the quotients, then delay to match the divider
  logic signed [PW-1:0] sa_lo, sa_hi, sb_lo, sb_hi;
  logic signed [PW-1:0] sh0, sh1, sh2, sh3, mn01, mn23, mx01, mx23;
  logic signed [PW-1:0] w_lo, w_hi;
  iau_pkg::sat_t        c_lo, c_hi;
  iau_pkg::mid_t        mid_nxt;
  iau_pkg::mid_t        dly_r [NW-1];

  always_comb begin
    sa_lo = PW'(s1_ent_r.item.a_lo);
    sa_hi = PW'(s1_ent_r.item.a_hi);
    sb_lo = PW'(s1_ent_r.item.b_lo);
    sb_hi = PW'(s1_ent_r.item.b_hi);
    sh0   = prod_r[0] >>> FB;
    sh1   = prod_r[1] >>> FB;
    sh2   = prod_r[2] >>> FB;
    sh3   = prod_r[3] >>> FB;
    mn01  = (sh0 < sh1) ? sh0 : sh1;
    mn23  = (sh2 < sh3) ? sh2 : sh3;
    mx01  = (sh0 > sh1) ? sh0 : sh1;
    mx23  = (sh2 > sh3) ? sh2 : sh3;
    w_lo  = '0;
    w_hi  = '0;
    mid_nxt              = '0;
    mid_nxt.valid        = s1_v_r;
    case (s1_ent_r.item.req_type)
      iau_pkg::OP_ADD: begin
        w_lo = sa_lo + sb_lo;
        w_hi = sa_hi + sb_hi;
      end
      iau_pkg::OP_SUB: begin
        w_lo = sa_lo - sb_hi;
        w_hi = sa_hi - sb_lo;
      end
      iau_pkg::OP_MUL: begin
        w_lo = (mn01 < mn23) ? mn01 : mn23;
        w_hi = (mx01 > mx23) ? mx01 : mx23;
      end
      iau_pkg::OP_SUBSET: begin
        mid_nxt.res.flag = (sa_hi <= sb_hi) && (sa_lo >= sb_lo);
      end
      iau_pkg::OP_EQUAL: begin
        mid_nxt.res.flag = (sa_lo == sb_lo) && (sa_hi == sb_hi);
      end
      iau_pkg::OP_CENTER: begin
        w_lo = (sa_lo + sa_hi) >>> 1;
        w_hi = (sa_hi - sa_lo) >>> 1;
      end
      iau_pkg::OP_WIDTH: begin
        w_lo = sa_hi - sa_lo;
        w_hi = sa_hi - sa_lo;
      end
      default: begin
        w_lo = '0;
        w_hi = '0;
      end
    endcase
    c_lo = iau_pkg::sat32(w_lo);
    c_hi = iau_pkg::sat32(w_hi);
    mid_nxt.res.res_lo = c_lo.val;
    mid_nxt.res.res_hi = c_hi.val;
    mid_nxt.res.status = (c_lo.sat || c_hi.sat) ? iau_pkg::ST_SAT : iau_pkg::ST_OK;
    if (s1_ent_r.bad) begin
      mid_nxt.res        = '0;
      mid_nxt.res.status = iau_pkg::ST_BAD_OPND;
    end else if (s1_ent_r.item.req_type == iau_pkg::OP_DIV) begin
      mid_nxt.res = '0;
      if (s1_ent_r.span) begin
        mid_nxt.res.status = iau_pkg::ST_DIV_SPAN;
      end else begin
        mid_nxt.div_ok = 1'b1;
      end
    end
  end

  for (genvar j = 0; j < NW - 1; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dly_r[j].valid <= 1'b0;
      end else if (en) begin
        dly_r[j].valid <= (j == 0) ? mid_nxt.valid : dly_r[(j == 0) ? 0 : j-1].valid;
      end
      if (en) begin
        if (j == 0) begin
          dly_r[j].div_ok <= mid_nxt.div_ok;
          dly_r[j].res    <= mid_nxt.res;
        end else begin
          dly_r[j].div_ok <= dly_r[(j == 0) ? 0 : j-1].div_ok;
          dly_r[j].res    <= dly_r[(j == 0) ? 0 : j-1].res;
        end
      end
    end
  end

  // ---- final: sign the quotients and saturate
  iau_pkg::mid_t        last;
  logic signed [NW:0]   sq_lo, sq_hi;
  iau_pkg::sat_t        d_lo, d_hi;
  iau_pkg::out_item_t   fin;

  always_comb begin
    last  = dly_r[NW-2];
    sq_lo = qlo_neg ? -$signed({1'b0, qlo}) : $signed({1'b0, qlo});
    sq_hi = qhi_neg ? -$signed({1'b0, qhi}) : $signed({1'b0, qhi});
    d_lo  = iau_pkg::sat32(PW'(sq_lo));
    d_hi  = iau_pkg::sat32(PW'(sq_hi));
    fin   = last.res;
    if (last.div_ok) begin
      fin.res_lo = d_lo.val;
      fin.res_hi = d_hi.val;
      fin.flag   = 1'b0;
      fin.status = (d_lo.sat || d_hi.sat) ? iau_pkg::ST_SAT : iau_pkg::ST_OK;
    end
  end

  // ---- output buffer
  assign push      = en && last.valid;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[0];
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (cnt_r == 2'd2) begin
        buf_r[0] <= buf_r[1];
      end else if (push) begin
        buf_r[0] <= fin;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        buf_r[0] <= fin;
      end else begin
        buf_r[1] <= fin;
      end
    end
  end

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1_v_r) && $stable(last.valid))
    else $error("pipeline moved while stalled");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == iau_pkg::ST_BAD_OPND) |->
    (out_data.res_lo == '0 && out_data.res_hi == '0 && !out_data.flag))
    else $error("invalid operand result not cleared");
  a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == iau_pkg::ST_DIV_SPAN) |->
    (out_data.res_lo == '0 && out_data.res_hi == '0))
    else $error("divisor span result not cleared");

endmodule
`default_nettype wire

### sv/interval_arithmetic_unit_top.sv
// Top level of the interval arithmetic unit.
//
// Interval ALU on signed Q16.16 endpoints: add, sub, mul, div, subset, equal,
// center/radius and width of two intervals, one result per transfer in. It
// takes one transfer per cycle and keeps that rate as long as out_ready is
// high. The pipe depth is set by the two restoring dividers, which give
// Q16.16 quotients and retire one quotient bit per stage; every op runs
// through the same fixed-depth pipe so results leave in order. A two-entry
// input queue feeds the pipe, and a two-entry output buffer decouples it
// from the consumer: when the buffer fills the whole back end freezes, the
// queue fills and in_ready drops. Multiplies use four 32x32 products
// registered before the min/max; quotients truncate toward zero, products
// and center/radius floor. Status reports invalid operands (lo>hi), a
// divisor that spans zero and saturation of any endpoint.
`default_nettype none
module interval_arithmetic_unit_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire iau_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output iau_pkg::out_item_t      out_data
);

  // head of the front queue, and the back end's take signal
  iau_pkg::q_head_t head;
  logic             pop;

  iau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .pop      (pop),
    .head     (head)
  );

  iau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the interval arithmetic unit: directed and random ops checked against a predictor.
`timescale 1ns / 1ps
module testbench;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  iau_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  iau_pkg::out_item_t out_data;

  interval_arithmetic_unit_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;

  iau_pkg::out_item_t expected_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        no_idle = 0;   // long stretch with both sides always ready/valid
  bit        timed_out = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // floor(v / 2^s); >>> on a signed 64-bit value floors already
  function automatic logic signed [63:0] floor_sh(input logic signed [63:0] v,
                                                  input int s);
    return v >>> s;
  endfunction

  // expected result of one interval op, computed at 64 bits then clamped
  function automatic iau_pkg::out_item_t interval_result(input iau_pkg::in_item_t it);
    iau_pkg::out_item_t r;
    logic signed [63:0] alo, ahi, blo, bhi, lo, hi, one;
    logic signed [63:0] p[4];
    bit sat;
    iau_pkg::op_t op;
    alo = it.a_lo; ahi = it.a_hi; blo = it.b_lo; bhi = it.b_hi;
    lo = 0; hi = 0; sat = 0;
    one = 64'sd1 <<< iau_pkg::FRAC_BITS;
    op = iau_pkg::op_t'(it.req_type);
    r = '0;
    if (alo > ahi ||
        (op != iau_pkg::OP_CENTER && op != iau_pkg::OP_WIDTH && blo > bhi)) begin
      r.status = iau_pkg::ST_BAD_OPND;
      return r;
    end
    case (op)
      iau_pkg::OP_ADD: begin lo = alo + blo; hi = ahi + bhi; end
      iau_pkg::OP_SUB: begin lo = alo - bhi; hi = ahi - blo; end
      iau_pkg::OP_MUL, iau_pkg::OP_DIV: begin
        if (op == iau_pkg::OP_DIV &&
            (blo == 0 || bhi == 0 || ((blo < 0) != (bhi < 0)))) begin
          r.status = iau_pkg::ST_DIV_SPAN;
          return r;
        end
        if (op == iau_pkg::OP_MUL) begin
          p[0] = floor_sh(alo * blo, iau_pkg::FRAC_BITS);
          p[1] = floor_sh(alo * bhi, iau_pkg::FRAC_BITS);
          p[2] = floor_sh(ahi * blo, iau_pkg::FRAC_BITS);
          p[3] = floor_sh(ahi * bhi, iau_pkg::FRAC_BITS);
        end else begin
          // SV signed division truncates toward zero, as the spec needs
          p[0] = (alo * one) / bhi; p[1] = (alo * one) / blo;
          p[2] = (ahi * one) / bhi; p[3] = (ahi * one) / blo;
        end
        lo = p[0]; hi = p[0];
        for (int i = 1; i < 4; i++) begin
          if (p[i] < lo) lo = p[i];
          if (p[i] > hi) hi = p[i];
        end
      end
      iau_pkg::OP_SUBSET: r.flag = (ahi <= bhi && alo >= blo);
      iau_pkg::OP_EQUAL:  r.flag = (alo == blo && ahi == bhi);
      iau_pkg::OP_CENTER: begin lo = floor_sh(alo + ahi, 1); hi = floor_sh(ahi - alo, 1); end
      default:   begin lo = ahi - alo; hi = lo; end
    endcase
    if (lo > 64'sh7FFF_FFFF) begin lo = 64'sh7FFF_FFFF; sat = 1; end
    if (lo < -64'sh8000_0000) begin lo = -64'sh8000_0000; sat = 1; end
    if (hi > 64'sh7FFF_FFFF) begin hi = 64'sh7FFF_FFFF; sat = 1; end
    if (hi < -64'sh8000_0000) begin hi = -64'sh8000_0000; sat = 1; end
    r.res_lo = lo[31:0];
    r.res_hi = hi[31:0];
    r.status = sat ? iau_pkg::ST_SAT : iau_pkg::ST_OK;
    return r;
  endfunction

  // one input transfer; valid held until accepted, random gaps before it
  task automatic send_interval_op(input iau_pkg::op_t op, input logic [31:0] alo,
                                  input logic [31:0] ahi, input logic [31:0] blo,
                                  input logic [31:0] bhi);
    iau_pkg::in_item_t it;
    it.req_type = op; it.a_lo = alo; it.a_hi = ahi; it.b_lo = blo; it.b_hi = bhi;
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(interval_result(it));
  endtask

  // result side: random stalls, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p, expected none", out_data);
        end else begin
          iau_pkg::out_item_t e;
          e = expected_q.pop_front();
          if (out_data.res_lo !== e.res_lo || out_data.res_hi !== e.res_hi ||
              out_data.flag !== e.flag || out_data.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected lo=%h hi=%h flag=%b st=%0d,",
                        " got lo=%h hi=%h flag=%b st=%0d"},
                       e.res_lo, e.res_hi, e.flag, e.status,
                       out_data.res_lo, out_data.res_hi, out_data.flag, out_data.status);
          end
        end
      end
      out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] rand_endpoint();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF - $urandom_range(3);
      2: return 32'sh8000_0000 + $urandom_range(3);
      3: return $urandom_range(2) - 1;
      default: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn, one;
    mx = 32'h7FFF_FFFF; mn = 32'h8000_0000; one = 32'h0001_0000;
    send_interval_op(iau_pkg::OP_ADD, mx, mx, one, one);        // saturates high
    send_interval_op(iau_pkg::OP_ADD, mn, mn, -one, 0);         // saturates low
    send_interval_op(iau_pkg::OP_SUB, mn, mx, mn, mx);
    send_interval_op(iau_pkg::OP_SUB, one, 2 * one, one, one);
    send_interval_op(iau_pkg::OP_MUL, -one, 2 * one, -3 * one, one);
    send_interval_op(iau_pkg::OP_MUL, mn, mx, mn, mx);
    send_interval_op(iau_pkg::OP_MUL, 32'hFFFF_FFFF, 1, 1, 1);  // floor of negative product
    send_interval_op(iau_pkg::OP_DIV, one, 2 * one, 0, one);    // divisor touches zero
    send_interval_op(iau_pkg::OP_DIV, one, 2 * one, -one, one); // divisor spans zero
    send_interval_op(iau_pkg::OP_DIV, -one, one, -2 * one, -one);
    send_interval_op(iau_pkg::OP_DIV, mn, mx, 1, 1);            // quotient saturates
    send_interval_op(iau_pkg::OP_DIV, -3, 7, 3 * one, 3 * one); // truncation toward zero
    send_interval_op(iau_pkg::OP_SUBSET, one, one, 0, 2 * one);
    send_interval_op(iau_pkg::OP_SUBSET, -one, one, 0, 2 * one);
    send_interval_op(iau_pkg::OP_EQUAL, one, 2 * one, one, 2 * one);
    send_interval_op(iau_pkg::OP_EQUAL, one, 2 * one, one, 3 * one);
    send_interval_op(iau_pkg::OP_CENTER, -3, 0, 5, 1);          // B ignored even if lo>hi
    send_interval_op(iau_pkg::OP_CENTER, mn, mx, 0, 0);
    send_interval_op(iau_pkg::OP_WIDTH, mn, mx, 0, 0);          // width saturates
    send_interval_op(iau_pkg::OP_WIDTH, one, one, 1, 0);
    send_interval_op(iau_pkg::OP_ADD, 2, 1, 0, 0);              // A lo>hi
    send_interval_op(iau_pkg::OP_DIV, 0, 1, 0, -1);             // invalid wins over span
    send_interval_op(iau_pkg::OP_WIDTH, 5, 4, 0, 0);
  endtask

  task automatic test_random(input int count);
    logic [31:0] a0, a1, b0, b1, t;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= count / 3 && n < count / 2);
      a0 = rand_endpoint(); a1 = rand_endpoint();
      b0 = rand_endpoint(); b1 = rand_endpoint();
      // mostly ordered intervals so ops reach past the operand check
      if ($urandom_range(9) != 0) begin
        if ($signed(a0) > $signed(a1)) begin t = a0; a0 = a1; a1 = t; end
        if ($signed(b0) > $signed(b1)) begin t = b0; b0 = b1; b1 = t; end
      end
      if ($urandom_range(7) == 0) begin b0 = a0; b1 = a1; end
      send_interval_op(iau_pkg::op_t'($urandom_range(7)), a0, a1, b0, b1);
    end
    no_idle = 0;
  endtask

  initial begin
    int waited;
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1150);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    timed_out = (expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && !timed_out) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

### filelist.f
sv/iau_pkg.sv
sv/iau_front.sv
sv/iau_div.sv
sv/iau_back.sv
sv/interval_arithmetic_unit_top.sv
tb/testbench.sv
